>>> hdl/matrix_slot_arith_engine_unit_assert.svh
// Assertion macros for the matrix slot engine checker.
// No dependencies.
`ifndef MATRIX_SLOT_ARITH_ENGINE_UNIT_ASSERT_SVH
`define MATRIX_SLOT_ARITH_ENGINE_UNIT_ASSERT_SVH
// implication checked each clock, disabled in reset
`define MSAE_IMPLIES(lbl, clk, rstn, a, b) \
lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) else $error("lbl");
// next-cycle implication
`define MSAE_NEXT(lbl, clk, rstn, a, b) \
lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error("lbl");
`endif

>>> hdl/msae_pkg.sv
// Package for the matrix slot engine: op and status codes.
// No dependencies.
`timescale 1ns / 1ps
package msae_pkg;
	typedef enum logic [2:0] {
		FN_CREATE = 3'd0, FN_WRITE = 3'd1, FN_SCALE = 3'd2,
		FN_ADD = 3'd3, FN_MUL = 3'd4, FN_READ = 3'd5
	} func_t;
	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_BAD_ID = 3'd1;
	localparam logic [2:0] ST_EMPTY = 3'd2;
	localparam logic [2:0] ST_DIM = 3'd3;
	localparam logic [2:0] ST_FULL = 3'd4;
	typedef struct packed {
		logic we;
		logic re;
	} mem_ctl_t;
endpackage

>>> hdl/msae_mem.sv
// Element store: one write port, one registered read port.
// Depends on msae_pkg.
`timescale 1ns / 1ps
module msae_mem import msae_pkg::*; #(
	parameter int DEPTH = 2048,
	parameter int AW = 11
) (
	input logic clk,
	input mem_ctl_t ctl,
	input logic [AW-1:0] waddr,
	input logic [31:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [31:0] rdata
);
	logic [31:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= wdata;
		end
		if (ctl.re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> hdl/matrix_slot_arith_engine_unit.sv
// Matrix slot engine: one op per beat over an element memory with one write port and one
// registered read port. Create clears the whole MAX_DIM*MAX_DIM slot footprint; scale and
// add run element by element; multiply clears the new slot, then sums K products per result
// element. A finished result waits while an earlier result has not been taken.
// One item at a time; the next is taken the cycle after its result is registered.
// Reset: all slots empty, then a clearing pass over every address zeroes the memory.
`timescale 1ns / 1ps
module matrix_slot_arith_engine_unit import msae_pkg::*; #(
	parameter int NUM_SLOTS = 8,
	parameter int MAX_DIM = 16
) (
	input logic clk,
	input logic arst_n,
	input logic valid_in,
	output logic ready_in,
	input logic [2:0] func,
	input logic [4:0] slot_a,
	input logic [4:0] slot_b,
	input logic [3:0] row_index,
	input logic [3:0] col_index,
	input logic signed [31:0] operand_value,
	output logic valid_out,
	input logic ready_out,
	output logic [2:0] status,
	output logic [2:0] result_slot,
	output logic signed [31:0] read_value
);
	localparam int DW = $clog2(MAX_DIM);
	localparam int SW = $clog2(NUM_SLOTS);
	localparam int AW = SW + 2 * DW;
	localparam int DEPTH = 1 << AW;
	localparam int CW = DW + 1;
	localparam int UW = SW + 1;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_DEC, S_ZERO, S_RD1, S_RD2, S_EW_A, S_EW_B, S_EW_W,
		S_MA, S_MB, S_MACC, S_MW, S_DONE
	} state_t;

	state_t state_q;
	logic [CW-1:0] rows_q [NUM_SLOTS];
	logic [CW-1:0] cols_q [NUM_SLOTS];
	logic [UW-1:0] used_q;
	logic [AW:0] clr_q;
	logic [2:0] func_q;
	logic [SW-1:0] a_q, b_q, d_q;
	logic [4:0] a5_q, b5_q;
	logic [3:0] r_in_q, c_in_q;
	logic [31:0] v_q, t_q, acc_q;
	logic [CW-1:0] i_q, j_q, m_q, nr_q, nc_q, k_q;
	logic [2:0] status_q, rslot_q;
	logic [31:0] rv_q;
	logic vo_q;
	logic [2:0] out_status_q, out_slot_q;
	logic [31:0] out_value_q;

	mem_ctl_t ctl;
	logic [AW-1:0] waddr, raddr;
	logic [31:0] wdata, rdata;

	msae_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
		.clk(clk), .ctl(ctl), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	function automatic logic [AW-1:0] cell_f(logic [SW-1:0] s, logic [CW-1:0] r,
			logic [CW-1:0] c);
		return {s, r[DW-1:0], c[DW-1:0]};
	endfunction

	logic [31:0] prod;
	assign prod = t_q * rdata;

	always_comb begin
		ctl = '0;
		waddr = '0;
		wdata = '0;
		raddr = '0;
		case (state_q)
			S_CLR: begin
				ctl.we = 1'b1;
				waddr = clr_q[AW-1:0];
			end
			S_ZERO: begin
				ctl.we = 1'b1;
				waddr = cell_f(d_q, i_q, j_q);
			end
			S_RD1: begin
				if (func_q == FN_WRITE) begin
					ctl.we = 1'b1;
					waddr = cell_f(a_q, CW'(r_in_q), CW'(c_in_q));
					wdata = v_q;
				end else begin
					ctl.re = 1'b1;
					raddr = cell_f(a_q, CW'(r_in_q), CW'(c_in_q));
				end
			end
			S_EW_A: begin
				ctl.re = 1'b1;
				raddr = cell_f(a_q, i_q, j_q);
			end
			S_EW_B: begin
				// scale keeps the A element on the read port
				ctl.re = (func_q == FN_ADD);
				raddr = cell_f(b_q, i_q, j_q);
			end
			S_EW_W: begin
				ctl.we = 1'b1;
				waddr = cell_f(a_q, i_q, j_q);
				wdata = (func_q == FN_SCALE) ? prod : t_q + rdata;
			end
			S_MA: begin
				ctl.re = 1'b1;
				raddr = cell_f(a_q, i_q, m_q);
			end
			S_MB: begin
				ctl.re = 1'b1;
				raddr = cell_f(b_q, m_q, j_q);
			end
			S_MW: begin
				ctl.we = 1'b1;
				waddr = cell_f(d_q, i_q, j_q);
				wdata = acc_q;
			end
			default: ;
		endcase
	end

	logic a_bad, b_bad, a_emp, b_emp;
	assign a_bad = a5_q >= 5'(NUM_SLOTS);
	assign b_bad = b5_q >= 5'(NUM_SLOTS);
	assign a_emp = 6'(a5_q) >= 6'(used_q);
	assign b_emp = 6'(b5_q) >= 6'(used_q);

	assign ready_in = (state_q == S_IDLE);
	assign valid_out = vo_q;
	assign status = out_status_q;
	assign result_slot = out_slot_q;
	assign read_value = out_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			used_q <= '0;
			vo_q <= 1'b0;
			out_status_q <= '0;
			out_slot_q <= '0;
			out_value_q <= '0;
			for (int s = 0; s < NUM_SLOTS; s++) begin
				rows_q[s] <= '0;
				cols_q[s] <= '0;
			end
		end else begin
			if (vo_q && ready_out && state_q != S_DONE) vo_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (valid_in) begin
					func_q <= func;
					a5_q <= slot_a;
					b5_q <= slot_b;
					a_q <= slot_a[SW-1:0];
					b_q <= slot_b[SW-1:0];
					r_in_q <= row_index;
					c_in_q <= col_index;
					v_q <= operand_value;
					status_q <= ST_OK;
					rslot_q <= '0;
					rv_q <= '0;
					state_q <= S_DEC;
				end
				S_DEC: begin
					i_q <= '0;
					j_q <= '0;
					m_q <= '0;
					acc_q <= '0;
					d_q <= used_q[SW-1:0];
					state_q <= S_DONE;
					case (func_q)
						FN_CREATE: begin
							if (8'(r_in_q) + 8'd1 > 8'(MAX_DIM)
									|| 8'(c_in_q) + 8'd1 > 8'(MAX_DIM)) status_q <= ST_DIM;
							else if (used_q >= UW'(NUM_SLOTS)) status_q <= ST_FULL;
							else begin
								nr_q <= CW'(r_in_q) + 1'b1;
								nc_q <= CW'(c_in_q) + 1'b1;
								rows_q[used_q[SW-1:0]] <= CW'(r_in_q) + 1'b1;
								cols_q[used_q[SW-1:0]] <= CW'(c_in_q) + 1'b1;
								rslot_q <= 3'(used_q);
								used_q <= used_q + 1'b1;
								state_q <= S_ZERO;
							end
						end
						FN_WRITE, FN_READ, FN_SCALE: begin
							if (a_bad) status_q <= ST_BAD_ID;
							else if (a_emp) status_q <= ST_EMPTY;
							else if (func_q != FN_SCALE && (8'(r_in_q) >= 8'(rows_q[a_q])
									|| 8'(c_in_q) >= 8'(cols_q[a_q]))) status_q <= ST_DIM;
							else if (func_q == FN_SCALE) begin
								nr_q <= rows_q[a_q];
								nc_q <= cols_q[a_q];
								t_q <= v_q;
								state_q <= S_EW_A;
							end else state_q <= S_RD1;
						end
						FN_ADD, FN_MUL: begin
							if (a_bad || b_bad) status_q <= ST_BAD_ID;
							else if (a_emp || b_emp) status_q <= ST_EMPTY;
							else if (func_q == FN_ADD) begin
								if (rows_q[a_q] != rows_q[b_q] || cols_q[a_q] != cols_q[b_q])
									status_q <= ST_DIM;
								else begin
									nr_q <= rows_q[a_q];
									nc_q <= cols_q[a_q];
									state_q <= S_EW_A;
								end
							end else begin
								if (cols_q[a_q] != rows_q[b_q]) status_q <= ST_DIM;
								else if (used_q >= UW'(NUM_SLOTS)) status_q <= ST_FULL;
								else begin
									nr_q <= rows_q[a_q];
									nc_q <= cols_q[b_q];
									k_q <= cols_q[a_q];
									rows_q[used_q[SW-1:0]] <= rows_q[a_q];
									cols_q[used_q[SW-1:0]] <= cols_q[b_q];
									rslot_q <= 3'(used_q);
									used_q <= used_q + 1'b1;
									state_q <= S_ZERO;
								end
							end
						end
						default: ;
					endcase
				end
				S_ZERO: begin
					// clear whole slot footprint
					j_q <= j_q + 1'b1;
					if (j_q == CW'(MAX_DIM - 1)) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
						if (i_q == CW'(MAX_DIM - 1)) begin
							i_q <= '0;
							state_q <= (func_q == FN_MUL) ? S_MA : S_DONE;
						end
					end
				end
				S_RD1: state_q <= (func_q == FN_WRITE) ? S_DONE : S_RD2;
				S_RD2: begin
					rv_q <= rdata;
					state_q <= S_DONE;
				end
				S_EW_A: state_q <= S_EW_B;
				S_EW_B: begin
					if (func_q == FN_ADD) t_q <= rdata;
					state_q <= S_EW_W;
				end
				S_EW_W: begin
					state_q <= S_EW_A;
					j_q <= j_q + 1'b1;
					if (j_q + 1'b1 == nc_q) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
						if (i_q + 1'b1 == nr_q) state_q <= S_DONE;
					end
				end
				S_MA: state_q <= S_MB;
				S_MB: begin
					t_q <= rdata;
					state_q <= S_MACC;
				end
				S_MACC: begin
					acc_q <= acc_q + prod;
					m_q <= m_q + 1'b1;
					state_q <= (m_q + 1'b1 == k_q) ? S_MW : S_MA;
				end
				S_MW: begin
					acc_q <= '0;
					m_q <= '0;
					state_q <= S_MA;
					j_q <= j_q + 1'b1;
					if (j_q + 1'b1 == nc_q) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
						if (i_q + 1'b1 == nr_q) state_q <= S_DONE;
					end
				end
				S_DONE: if (!vo_q || ready_out) begin
					vo_q <= 1'b1;
					out_status_q <= status_q;
					out_slot_q <= rslot_q;
					out_value_q <= rv_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> hdl/msae_checker.sv
// Port-level checker for the matrix slot engine, bound to the top level.
// Depends on msae_pkg and matrix_slot_arith_engine_unit_assert.svh.
`timescale 1ns / 1ps
`include "matrix_slot_arith_engine_unit_assert.svh"
module msae_checker import msae_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic valid_in,
	input logic ready_in,
	input logic valid_out,
	input logic ready_out,
	input logic [2:0] status,
	input logic [2:0] result_slot,
	input logic signed [31:0] read_value
);
	`MSAE_NEXT(a_busy_after_in, clk, arst_n, valid_in && ready_in, !ready_in)
	`MSAE_IMPLIES(a_status_range, clk, arst_n, valid_out, status <= ST_FULL)
	`MSAE_IMPLIES(a_err_no_slot, clk, arst_n, valid_out && status != ST_OK,
		result_slot == 3'd0 && read_value == 32'sd0)
	`MSAE_NEXT(a_out_hold, clk, arst_n, valid_out && !ready_out,
		valid_out && $stable(status) && $stable(read_value))
endmodule

bind matrix_slot_arith_engine_unit msae_checker u_msae_checker (
	.clk(clk), .arst_n(arst_n), .valid_in(valid_in), .ready_in(ready_in),
	.valid_out(valid_out), .ready_out(ready_out), .status(status),
	.result_slot(result_slot), .read_value(read_value)
);

>>> bench/matrix_slot_arith_engine_unit_chk.sv
// Checker for the matrix slot engine: watches both channels, predicts each
// result from its own copy of the slot store and compares field by field.
// Depends on msae_pkg for the op and status codes.
`timescale 1ns / 1ps
module matrix_slot_arith_engine_unit_chk import msae_pkg::*; #(
	parameter int NUM_SLOTS = 8,
	parameter int MAX_DIM = 16
) (
	input logic clk,
	input logic arst_n,
	input logic valid_in,
	input logic ready_in,
	input logic [2:0] func,
	input logic [4:0] slot_a,
	input logic [4:0] slot_b,
	input logic [3:0] row_index,
	input logic [3:0] col_index,
	input logic signed [31:0] operand_value,
	input logic valid_out,
	input logic ready_out,
	input logic [2:0] status,
	input logic [2:0] result_slot,
	input logic signed [31:0] read_value,
	output int errors,
	output int pending
);
	typedef struct {
		logic [2:0] st;
		logic [2:0] slot;
		logic [31:0] val;
	} outcome_t;

	logic [31:0] elems [NUM_SLOTS][MAX_DIM][MAX_DIM];
	int rows [NUM_SLOTS] = '{default: 0};
	int cols [NUM_SLOTS] = '{default: 0};
	int used = 0;
	int fails = 0;
	outcome_t outcomes [$];

	assign errors = fails;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
		fails++;
	endtask

	task automatic open_slot(input int nr, input int nc);
		for (int i = 0; i < MAX_DIM; i++)
			for (int j = 0; j < MAX_DIM; j++)
				elems[used][i][j] = '0;
		rows[used] = nr;
		cols[used] = nc;
		used++;
	endtask

	task automatic predict_op(input logic [2:0] f, input int a, input int b, input int r,
			input int c, input logic [31:0] v, output outcome_t o);
		logic [31:0] acc;
		int d;
		o.st = ST_OK;
		o.slot = '0;
		o.val = '0;
		if (f == FN_CREATE) begin
			if (r + 1 > MAX_DIM || c + 1 > MAX_DIM) o.st = ST_DIM;
			else if (used >= NUM_SLOTS) o.st = ST_FULL;
			else begin
				o.slot = used[2:0];
				open_slot(r + 1, c + 1);
			end
		end else if (f == FN_WRITE || f == FN_SCALE || f == FN_READ) begin
			if (a >= NUM_SLOTS) o.st = ST_BAD_ID;
			else if (a >= used) o.st = ST_EMPTY;
			else if (f != FN_SCALE && (r >= rows[a] || c >= cols[a])) o.st = ST_DIM;
			if (o.st == ST_OK) begin
				if (f == FN_WRITE) elems[a][r][c] = v;
				else if (f == FN_READ) o.val = elems[a][r][c];
				else
					for (int i = 0; i < rows[a]; i++)
						for (int j = 0; j < cols[a]; j++)
							elems[a][i][j] = elems[a][i][j] * v;
			end
		end else if (f == FN_ADD || f == FN_MUL) begin
			if (a >= NUM_SLOTS || b >= NUM_SLOTS) o.st = ST_BAD_ID;
			else if (a >= used || b >= used) o.st = ST_EMPTY;
			else if (f == FN_ADD) begin
				if (rows[a] != rows[b] || cols[a] != cols[b]) o.st = ST_DIM;
				else
					for (int i = 0; i < rows[a]; i++)
						for (int j = 0; j < cols[a]; j++)
							elems[a][i][j] = elems[a][i][j] + elems[b][i][j];
			end else begin
				if (cols[a] != rows[b]) o.st = ST_DIM;
				else if (used >= NUM_SLOTS) o.st = ST_FULL;
				else begin
					d = used;
					open_slot(rows[a], cols[b]);
					for (int i = 0; i < rows[a]; i++)
						for (int j = 0; j < cols[b]; j++) begin
							acc = '0;
							for (int m = 0; m < cols[a]; m++)
								acc = acc + elems[a][i][m] * elems[b][m][j];
							elems[d][i][j] = acc;
						end
					o.slot = d[2:0];
				end
			end
		end
	endtask

	always @(posedge clk) begin
		outcome_t o;
		outcome_t w;
		if (arst_n) begin
			if (valid_in && ready_in) begin
				predict_op(func, int'(slot_a), int'(slot_b), int'(row_index), int'(col_index),
					operand_value, o);
				outcomes.push_back(o);
			end
			if (valid_out && ready_out) begin
				if (outcomes.size() == 0) begin
					report("unexpected beat", 32'(status), '0);
				end else begin
					w = outcomes.pop_front();
					if (status !== w.st) report("status", 32'(status), 32'(w.st));
					if (result_slot !== w.slot)
						report("result_slot", 32'(result_slot), 32'(w.slot));
					if (read_value !== w.val) report("read_value", read_value, w.val);
				end
			end
		end
		pending = outcomes.size();
	end
endmodule

>>> bench/matrix_slot_arith_engine_unit_tb.sv
// Testbench top for the matrix slot engine: directed then random ops with
// varying idle on both sides; verdict from the checker's failure count.
// Depends on msae_pkg, matrix_slot_arith_engine_unit and its checker.
`timescale 1ns / 1ps
module matrix_slot_arith_engine_unit_tb;
	import msae_pkg::*;

	localparam logic [2:0] FN_SPARE6 = 3'd6;
	localparam logic [2:0] FN_SPARE7 = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic valid_in = 1'b0;
	logic ready_in;
	logic [2:0] func = '0;
	logic [4:0] slot_a = '0;
	logic [4:0] slot_b = '0;
	logic [3:0] row_index = '0;
	logic [3:0] col_index = '0;
	logic signed [31:0] operand_value = '0;
	logic valid_out;
	logic ready_out = 1'b0;
	logic [2:0] status;
	logic [2:0] result_slot;
	logic signed [31:0] read_value;
	int errors;
	int pending;
	int phase = 0;
	int send_idle = 19;
	int recv_idle = 79;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	matrix_slot_arith_engine_unit dut (.*);

	matrix_slot_arith_engine_unit_chk chk (.*);

	initial begin
		#50ms;
		$display("matrix_slot_arith_engine_unit_tb: FAIL");
		$finish;
	end

	// receiver; a long hold-off on entering the last phase
	initial begin
		bit held;
		held = 0;
		forever begin
			@(negedge clk);
			if (phase == 2 && !held) begin
				held = 1;
				ready_out <= 1'b0;
				repeat (300) @(negedge clk);
			end
			ready_out <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic send(input logic [2:0] f, input int a, input int b,
			input int r, input int c, input logic [31:0] v);
		bit took;
		while ($urandom_range(99) < send_idle) begin
			valid_in <= 1'b0;
			@(negedge clk);
		end
		valid_in <= 1'b1;
		func <= f;
		slot_a <= 5'(a);
		slot_b <= 5'(b);
		row_index <= 4'(r);
		col_index <= 4'(c);
		operand_value <= v;
		do begin
			#1 took = ready_in;
			@(negedge clk);
		end while (!took);
	endtask

	task automatic send_random();
		int pick;
		logic [2:0] f;
		int a;
		int b;
		int r;
		int c;
		pick = $urandom_range(99);
		if (pick < 30) f = FN_WRITE;
		else if (pick < 55) f = FN_READ;
		else if (pick < 65) f = FN_SCALE;
		else if (pick < 77) f = FN_ADD;
		else if (pick < 89) f = FN_MUL;
		else if (pick < 95) f = FN_CREATE;
		else f = $urandom_range(1) ? FN_SPARE6 : FN_SPARE7;
		a = ($urandom_range(9) < 8) ? $urandom_range(7) : $urandom_range(31);
		b = ($urandom_range(9) < 8) ? $urandom_range(7) : $urandom_range(31);
		r = $urandom_range(1) ? $urandom_range(2) : $urandom_range(15);
		c = $urandom_range(1) ? $urandom_range(2) : $urandom_range(15);
		send(f, a, b, r, c, $urandom());
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		send(FN_CREATE, 0, 0, 0, 0, 0);
		send(FN_CREATE, 0, 0, 15, 15, 0);
		send(FN_CREATE, 0, 0, 1, 2, 0);
		send(FN_CREATE, 0, 0, 2, 1, 0);
		send(FN_WRITE, 2, 0, 0, 0, 32'h7fffffff);
		send(FN_WRITE, 2, 0, 1, 2, 32'h80000000);
		send(FN_WRITE, 3, 0, 2, 1, 32'hffffffff);
		send(FN_WRITE, 1, 0, 15, 15, $urandom());
		send(FN_WRITE, 2, 0, 2, 0, 5);
		send(FN_READ, 2, 0, 1, 2, 0);
		send(FN_SCALE, 2, 0, 0, 0, 32'hffffffff);
		send(FN_ADD, 2, 2, 0, 0, 0);
		send(FN_ADD, 2, 3, 0, 0, 0);
		send(FN_MUL, 2, 3, 0, 0, 0);
		send(FN_MUL, 2, 2, 0, 0, 0);
		send(FN_MUL, 1, 1, 0, 0, 0);
		send(FN_READ, 31, 0, 0, 0, 0);
		send(FN_ADD, 0, 8, 0, 0, 0);
		send(FN_READ, 7, 0, 0, 0, 0);
		send(FN_SPARE6, 31, 31, 15, 15, 32'hffffffff);
		send(FN_SPARE7, 0, 0, 0, 0, 0);
		send(FN_CREATE, 0, 0, 0, 0, 0);
		send(FN_CREATE, 0, 0, 3, 3, 0);
		send(FN_CREATE, 0, 0, 0, 0, 0);
		send(FN_MUL, 0, 0, 0, 0, 0);
		for (int n = 0; n < 115; n++) begin
			if (n == 38) begin
				phase = 1;
				send_idle = 79;
				recv_idle = 19;
			end else if (n == 77) begin
				phase = 2;
				send_idle = 0;
				recv_idle = 0;
			end
			send_random();
		end
		valid_in <= 1'b0;
		wait (pending == 0);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("matrix_slot_arith_engine_unit_tb: PASS");
		else
			$display("matrix_slot_arith_engine_unit_tb: FAIL");
		$finish;
	end
endmodule
